// ----- design/assert_macros.svh -----
// Assertion macros for the NEC IR decoder checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define NEC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define NEC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define NEC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: post-reset check failed");

`endif

// ----- design/nec_ir_pkg.sv -----
// Shared types and constants for the NEC IR frame decoder.
// No dependencies; imported by every decoder module.
package nec_ir_pkg;

   localparam int unsigned CFG_COUNT   = 8;
   localparam int unsigned CSR_INDEX_W = 4;

   // Configuration register map
   typedef enum logic [2:0] {
      CFG_LEADER_MARK   = 3'd0,
      CFG_LEADER_SPACE  = 3'd1,
      CFG_LEADER_TOL    = 3'd2,
      CFG_BIT_MARK      = 3'd3,
      CFG_BIT_MARK_TOL  = 3'd4,
      CFG_ZERO_SPACE    = 3'd5,
      CFG_ONE_SPACE     = 3'd6,
      CFG_SPACE_TOL     = 3'd7
   } cfg_index_type;

   localparam int unsigned CFG_RESET [CFG_COUNT] =
      '{9000, 4500, 1200, 560, 300, 560, 1690, 500};

   localparam int unsigned DATA_BITS   = 32;
   localparam logic [5:0]  FRAME_SYMBOLS = 6'd33;

   // Classified symbol handed from the front to the back
   typedef struct packed {
      logic last;
      logic leader_ok;
      logic mark_ok;
      logic zero_ok;
      logic one_ok;
   } sym_class_type;

   localparam int unsigned FIFO_DEPTH = 2;
   localparam int unsigned FIFO_PTR_W = 1;

endpackage

// ----- design/nec_ir_front.sv -----
// Front end: configuration registers and window classification of a symbol.
// Depends on nec_ir_pkg.
module nec_ir_front import nec_ir_pkg::*; #(
   parameter int unsigned DURATION_WIDTH = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [DURATION_WIDTH-1:0]  csr_data,
   input  logic [DURATION_WIDTH-1:0]  mark_duration,
   input  logic [DURATION_WIDTH-1:0]  space_duration,
   input  logic                       last_symbol,
   output sym_class_type              sym_class
);

   logic [DURATION_WIDTH-1:0] cfg_ff [CFG_COUNT];

   function automatic logic in_window(input logic [DURATION_WIDTH-1:0] v,
                                      input logic [DURATION_WIDTH-1:0] t,
                                      input logic [DURATION_WIDTH-1:0] tol);
      logic [DURATION_WIDTH:0] lo;
      logic [DURATION_WIDTH:0] hi;
      lo = (t > tol) ? {1'b0, t - tol} : '0;   // low edge clamps at zero
      hi = {1'b0, t} + {1'b0, tol};
      return ({1'b0, v} >= lo) && ({1'b0, v} <= hi);
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_COUNT; i++) begin
            cfg_ff[i] <= DURATION_WIDTH'(CFG_RESET[i]);
         end
      end else if (csr_valid && (csr_index[CSR_INDEX_W-1:3] == '0)) begin
         cfg_ff[csr_index[2:0]] <= csr_data;
      end
   end

   always_comb begin
      sym_class.last      = last_symbol;
      sym_class.leader_ok =
         in_window(mark_duration, cfg_ff[CFG_LEADER_MARK], cfg_ff[CFG_LEADER_TOL]) &&
         in_window(space_duration, cfg_ff[CFG_LEADER_SPACE], cfg_ff[CFG_LEADER_TOL]);
      sym_class.mark_ok   =
         in_window(mark_duration, cfg_ff[CFG_BIT_MARK], cfg_ff[CFG_BIT_MARK_TOL]);
      sym_class.zero_ok   =
         in_window(space_duration, cfg_ff[CFG_ZERO_SPACE], cfg_ff[CFG_SPACE_TOL]);
      sym_class.one_ok    =
         in_window(space_duration, cfg_ff[CFG_ONE_SPACE], cfg_ff[CFG_SPACE_TOL]);
   end

endmodule

// ----- design/nec_ir_fifo.sv -----
// Two-entry queue of classified symbols between front and back.
// Depends on nec_ir_pkg.
module nec_ir_fifo import nec_ir_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sym_class_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output sym_class_type head
);

   sym_class_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_PTR_W:0]     count_ff;

   assign full  = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop && !empty) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         unique case ({push && !full, pop && !empty})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ----- design/nec_ir_back.sv -----
// Back end: frame sequencing, bit collection and the result register.
// Depends on nec_ir_pkg.
module nec_ir_back import nec_ir_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   input  sym_class_type head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_frame_valid,
   output logic [31:0]   rsp_decoded_code
);

   logic [5:0]  count_ff, count_in;
   logic [31:0] code_ff, code_in;
   logic        failed_ff, failed_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_ok_ff, out_ok_in;
   logic [31:0] out_code_ff, out_code_in;
   logic [4:0]  bit_idx;
   logic        ok;

   // Non-last symbols never need the result slot
   assign pop = !empty && (!head.last || !out_valid_ff || rsp_ready);
   assign bit_idx = 5'(count_ff - 6'd1);

   always_comb begin
      count_in     = count_ff;
      code_in      = code_ff;
      failed_in    = failed_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_ok_in    = out_ok_ff;
      out_code_in  = out_code_ff;
      ok           = 1'b0;
      if (pop) begin
         priority if (count_ff == '0) begin
            if (!head.leader_ok) failed_in = 1'b1;
         end else if (count_ff <= 6'(DATA_BITS)) begin
            priority if (!head.mark_ok) failed_in = 1'b1;
            else if (head.zero_ok) code_in = code_ff;
            else if (head.one_ok) code_in = code_ff | (32'd1 << bit_idx);
            else failed_in = 1'b1;
         end else begin
            count_in = count_ff;   // symbols past the frame are ignored
         end
         if (count_ff < FRAME_SYMBOLS) count_in = count_ff + 6'd1;
         if (head.last) begin
            ok           = !failed_in && (count_in >= FRAME_SYMBOLS);
            out_valid_in = 1'b1;
            out_ok_in    = ok;
            out_code_in  = ok ? code_in : '0;
            count_in     = '0;
            code_in      = '0;
            failed_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         code_ff      <= '0;
         failed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         code_ff      <= code_in;
         failed_ff    <= failed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ok_ff   <= out_ok_in;
      out_code_ff <= out_code_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_valid  = out_ok_ff;
   assign rsp_decoded_code = out_code_ff;

endmodule

// ----- design/nec_ir_frame_decoder_core.sv -----
// Top level of the NEC IR frame decoder.
// Depends on nec_ir_pkg, nec_ir_front, nec_ir_fifo and nec_ir_back.
//
// Usage:
//  - req_* carries one captured pulse symbol per transaction: mark and space
//    durations in microseconds and a flag on the frame's last symbol.
//  - rsp_* carries one transaction per frame, produced by the last symbol:
//    frame_valid and the 32-bit code (first received bit in bit 0, 0 when
//    the frame is short or any timing window missed).
//  - csr_* writes the eight timing registers (index 0..7, higher indexes
//    are dropped); csr_ready is always high. Write only while idle.
//  - Throughput: one symbol per cycle while req_ready is high; a symbol is
//    classified in its accepting cycle and queued, and the back end retires
//    one per cycle unless a last symbol waits for the result slot.
//  - Result: a queued last symbol loads the free result register, raising rsp_valid.
//  - Stall: a pending result holds its register; non-last symbols keep
//    flowing, and req_ready drops only once the two-entry queue fills
//    behind a last symbol waiting for the result slot.
//  - Reset: timing registers return to nominal NEC values, queue and frame
//    state clear, no result is pending.
module nec_ir_frame_decoder_core import nec_ir_pkg::*; #(
   parameter int unsigned DURATION_WIDTH = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [DURATION_WIDTH-1:0]  req_mark_duration,
   input  logic [DURATION_WIDTH-1:0]  req_space_duration,
   input  logic                       req_last_symbol,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_frame_valid,
   output logic [31:0]                rsp_decoded_code,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [DURATION_WIDTH-1:0]  csr_data
);

   sym_class_type sym_class;
   sym_class_type q_head;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;

   // Front: window checks are pure logic off the request fields
   nec_ir_front #(.DURATION_WIDTH(DURATION_WIDTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mark_duration  (req_mark_duration),
      .space_duration (req_space_duration),
      .last_symbol    (req_last_symbol),
      .sym_class      (sym_class)
   );

   assign req_ready = !q_full;

   nec_ir_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (sym_class),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Back: per-frame sequencing and the output register
   nec_ir_back u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (q_empty),
      .head             (q_head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_valid  (rsp_frame_valid),
      .rsp_decoded_code (rsp_decoded_code)
   );

endmodule

// ----- design/nec_ir_checker.sv -----
// Port-level checker for the NEC IR frame decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module nec_ir_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_frame_valid,
   input logic [31:0] rsp_decoded_code
);

   // A rejected frame always carries a zero code
   `NEC_ASSERT_IMP(a_fail_code_zero, clock, reset, rsp_valid && !rsp_frame_valid, rsp_decoded_code == 32'd0)

   // Reset leaves req_ready high and no result pending
   `NEC_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, req_ready && !rsp_valid)

   // A stalled result holds
   `NEC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_valid) && $stable(rsp_decoded_code))

   // With no result pending, the queue always drains enough to take a symbol
   `NEC_ASSERT_NXT(a_no_stall_idle, clock, reset, !rsp_valid, req_ready)

endmodule

bind nec_ir_frame_decoder_core nec_ir_checker u_nec_ir_checker (.*);
